// ===== rtl/core/sapm_pkg.sv =====
// ----------------------------------------------------------------------------
// sapm_pkg
// Shared sizes, types and constants of the pivot move checker.
// ----------------------------------------------------------------------------
package sapm_pkg;

  // Walk geometry.
  localparam int WALK_LEN = 16;
  localparam int DIMS     = 2;

  // Number of distinct step codes, the code width that follows from it, and the index and coordinate widths.
  localparam int NUM_CODES = 2 * DIMS;
  localparam int CODE_W    = $clog2(NUM_CODES);
  localparam int IDX_W     = $clog2(WALK_LEN);
  localparam int COORD_W   = $clog2(WALK_LEN) + 1;

  // Width of the fixed input fields.
  localparam int PIVOT_W = 4;
  localparam int ROT_W   = 2;

  // Width used to compare a walk index against the pivot index.
  localparam int CMP_W = (IDX_W > PIVOT_W) ? IDX_W : PIVOT_W;

  // Command codes.
  localparam logic CMD_RESET = 1'b0;
  localparam logic CMD_PIVOT = 1'b1;

  // Side codes.
  localparam logic SIDE_LOW  = 1'b0;
  localparam logic SIDE_HIGH = 1'b1;

  // Step codes.
  localparam logic [2:0] STEP_POS_Y = 3'd0;
  localparam logic [2:0] STEP_POS_X = 3'd1;
  localparam logic [2:0] STEP_NEG_Y = 3'd2;
  localparam logic [2:0] STEP_NEG_X = 3'd3;
  localparam logic [2:0] STEP_POS_Z = 3'd4;
  localparam logic [2:0] STEP_NEG_Z = 3'd5;

  typedef logic [CODE_W-1:0]         code_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [DIMS-1:0]         pos_t;

endpackage

// ===== rtl/core/sapm_step.sv =====
// ----------------------------------------------------------------------------
// sapm_step
// Shared step unit: rotates one step code and advances the running vertex.
// ----------------------------------------------------------------------------
module sapm_step (
  input  sapm_pkg::code_t                 code_i,
  input  logic                            rotate_i,
  input  logic [sapm_pkg::ROT_W-1:0]      rotation_i,
  input  logic                            origin_i,
  input  sapm_pkg::pos_t                  pos_i,
  output sapm_pkg::code_t                 code_o,
  output sapm_pkg::pos_t                  pos_o
);
  import sapm_pkg::*;

  localparam int SUM_W = CODE_W + 2;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] wrapped;
  logic [2:0]       code_ext;
  logic [1:0]       axis;
  logic             negative;

  // Codes are always below the modulus and the rotation is below it too,
  // so one conditional subtract completes the modulo.
  always_comb begin
    sum = SUM_W'(code_i) + SUM_W'(rotation_i);
    if (sum >= SUM_W'(NUM_CODES)) begin
      wrapped = sum - SUM_W'(NUM_CODES);
    end else begin
      wrapped = sum;
    end
    code_o = rotate_i ? CODE_W'(wrapped) : code_i;
  end

  always_comb begin
    code_ext = 3'(code_o);
    case (code_ext)
      STEP_POS_Y: begin axis = 2'd1; negative = 1'b0; end
      STEP_POS_X: begin axis = 2'd0; negative = 1'b0; end
      STEP_NEG_Y: begin axis = 2'd1; negative = 1'b1; end
      STEP_NEG_X: begin axis = 2'd0; negative = 1'b1; end
      STEP_POS_Z: begin axis = 2'd2; negative = 1'b0; end
      STEP_NEG_Z: begin axis = 2'd2; negative = 1'b1; end
      default:    begin axis = 2'd3; negative = 1'b0; end
    endcase
  end

  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      if (origin_i) begin
        pos_o[d] = '0;
      end else if (d == int'(axis)) begin
        pos_o[d] = negative ? pos_i[d] - coord_t'(1) : pos_i[d] + coord_t'(1);
      end else begin
        pos_o[d] = pos_i[d];
      end
    end
  end

endmodule

// ===== rtl/core/sapm_pos_ram.sv =====
// ----------------------------------------------------------------------------
// sapm_pos_ram
// Vertex position store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sapm_pos_ram (
  input  logic           clk_i,
  input  logic           we_i,
  input  sapm_pkg::idx_t waddr_i,
  input  sapm_pkg::pos_t wdata_i,
  input  sapm_pkg::idx_t raddr_i,
  output sapm_pkg::pos_t rdata_o
);
  import sapm_pkg::*;

  pos_t mem [WALK_LEN];
  pos_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/saw_pivot_move_checker.sv =====
// ----------------------------------------------------------------------------
// saw_pivot_move_checker
// Pivot move checker for a self-avoiding lattice walk.
// ----------------------------------------------------------------------------
// The block holds a walk as one step code per vertex. An input transaction
// carries a command: reset makes the walk straight, pivot rotates the codes
// below the pivot index (side 0) or from it upward (side 1) and keeps the
// move only if the rebuilt walk still avoids itself. Each input transaction
// yields exactly one output transaction whose accepted bit is 1 for a reset
// or a kept move and 0 for a move that was undone.
//
// A reset command is handled without leaving the idle state. A pivot command
// first walks the codes once through the shared step unit, one vertex per
// cycle, writing positions into the position RAM. It then streams the RAM
// through its single read port, comparing every later vertex against a
// latched earlier one: (WALK_LEN-1)*(WALK_LEN+2)/2 reads, 135 for a walk of
// 16, followed by a drain state and a finish state. The single read port of
// the position RAM bounds the check pass. One command is in work at a time.
//
// in_ready_o is high only while the sequencer is idle and the output register
// is free or being emptied in the same cycle. If the receiver stalls, the
// result waits in the output register and a finished pivot holds its result
// until the register drains. Reset clears the walk to a straight line and
// empties the output register.
// ----------------------------------------------------------------------------
module saw_pivot_move_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [sapm_pkg::PIVOT_W-1:0] pivot_index_i,
  input  logic                         side_i,
  input  logic [sapm_pkg::ROT_W-1:0]   rotation_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         accepted_o
);
  import sapm_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_BUILD  = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  localparam idx_t LAST_IDX = idx_t'(WALK_LEN - 1);
  localparam idx_t LAST_A   = idx_t'(WALK_LEN - 2);

  logic [2:0] state_q;

  // The committed walk and the candidate walk built during a pivot.
  code_t walk_q  [WALK_LEN];
  code_t trial_q [WALK_LEN];

  // Latched command fields.
  logic [PIVOT_W-1:0] pivot_q;
  logic               side_q;
  logic [ROT_W-1:0]   rot_q;

  // Build pass.
  idx_t  k_q;
  pos_t  pos_q;
  code_t step_code;
  pos_t  step_pos;
  logic  rotate_en;

  // Check pass.
  idx_t a_q;
  idx_t b_q;
  logic cmp_v_q;
  logic tag_a_q;
  pos_t pos_a_q;
  pos_t rd_data;
  logic hit_q;

  // Output register.
  logic out_valid_q;
  logic accepted_q;

  logic in_fire;
  logic out_free;
  logic out_load;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // A new result enters the output register this cycle.
  assign out_load = (in_fire && (command_i == CMD_RESET)) ||
                    ((state_q == ST_FINISH) && out_free);

  assign out_valid_o = out_valid_q;
  assign accepted_o  = accepted_q;

  // A code is rotated when its index lies on the chosen side of the pivot.
  always_comb begin
    if (side_q == SIDE_LOW) begin
      rotate_en = CMP_W'(k_q) < CMP_W'(pivot_q);
    end else begin
      rotate_en = CMP_W'(k_q) >= CMP_W'(pivot_q);
    end
  end

  sapm_step u_step (
    .code_i     (walk_q[k_q]),
    .rotate_i   (rotate_en),
    .rotation_i (rot_q),
    .origin_i   (k_q == '0),
    .pos_i      (pos_q),
    .code_o     (step_code),
    .pos_o      (step_pos)
  );

  // The build pass writes; the check pass reads from b_q, which also walks
  // over the anchor vertex a_q at the start of each row.
  sapm_pos_ram u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_BUILD),
    .waddr_i (k_q),
    .wdata_i (step_pos),
    .raddr_i (b_q),
    .rdata_o (rd_data)
  );

  // Candidate codes and running position need no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_BUILD) begin
      trial_q[k_q] <= step_code;
      pos_q        <= step_pos;
    end
    if (in_fire) begin
      pivot_q <= pivot_index_i;
      side_q  <= side_i;
      rot_q   <= rotation_i;
    end
    if (cmp_v_q && tag_a_q) begin
      pos_a_q <= rd_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      a_q         <= '0;
      b_q         <= '0;
      cmp_v_q     <= 1'b0;
      tag_a_q     <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      accepted_q  <= 1'b0;
      for (int i = 0; i < WALK_LEN; i++) begin
        walk_q[i] <= '0;
      end
    end else begin
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end

      // Compare stage behind the RAM read register.
      if (cmp_v_q && !tag_a_q && (rd_data == pos_a_q)) begin
        hit_q <= 1'b1;
      end

      unique case (state_q)
        ST_IDLE: begin
          cmp_v_q <= 1'b0;
          if (in_fire) begin
            if (command_i == CMD_RESET) begin
              for (int i = 0; i < WALK_LEN; i++) begin
                walk_q[i] <= '0;
              end
              out_valid_q <= 1'b1;
              accepted_q  <= 1'b1;
            end else begin
              k_q     <= '0;
              state_q <= ST_BUILD;
            end
          end
        end

        ST_BUILD: begin
          if (k_q == LAST_IDX) begin
            a_q     <= '0;
            b_q     <= '0;
            hit_q   <= 1'b0;
            state_q <= ST_CHECK;
          end else begin
            k_q <= k_q + idx_t'(1);
          end
        end

        ST_CHECK: begin
          cmp_v_q <= 1'b1;
          tag_a_q <= (b_q == a_q);
          if (b_q == LAST_IDX) begin
            if (a_q == LAST_A) begin
              state_q <= ST_DRAIN;
            end else begin
              a_q <= a_q + idx_t'(1);
              b_q <= a_q + idx_t'(1);
            end
          end else begin
            b_q <= b_q + idx_t'(1);
          end
        end

        ST_DRAIN: begin
          cmp_v_q <= 1'b0;
          state_q <= ST_FINISH;
        end

        ST_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            accepted_q  <= !hit_q;
            if (!hit_q) begin
              for (int i = 0; i < WALK_LEN; i++) begin
                walk_q[i] <= trial_q[i];
              end
            end
            state_q <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== bench/tb_saw_pivot_move_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_saw_pivot_move_checker
// Self-checking bench for the lattice walk pivot move checker.
// ----------------------------------------------------------------------------
// A behavioral copy of the walk lives in the bench. Every input transaction
// that the block takes is applied to it, and the accepted bit that it predicts
// is queued. A monitor compares each output transaction against the head of
// that queue. The stimulus runs a directed set of corner moves, a long random
// run of pivot moves with occasional resets, a stretch where the receiver
// holds off long enough to back the block up, and a final part with no idling.
// ----------------------------------------------------------------------------
module tb_saw_pivot_move_checker;
  import sapm_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               command_i;
  logic [PIVOT_W-1:0] pivot_index_i;
  logic               side_i;
  logic [ROT_W-1:0]   rotation_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               accepted_o;

  // Step codes of the bench's own copy of the walk, one per vertex.
  code_t walk_model_codes [WALK_LEN];

  // Predicted accepted bits, oldest first.
  logic  accepted_expected_q [$];

  int    error_count;

  // When set, both the sender and the receiver insert random idle bursts.
  bit    idle_enabled;

  // Set by a test to ask the receiver for one long hold-off.
  bit    hold_off_pending;

  localparam int HOLD_OFF_CYCLES = 600;
  localparam int DRAIN_CYCLES    = 200;

  saw_pivot_move_checker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .pivot_index_i (pivot_index_i),
    .side_i        (side_i),
    .rotation_i    (rotation_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .accepted_o    (accepted_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Applies one command to the walk copy and returns the accepted bit the block
  // should report. A pivot rotates a range of codes, rebuilds the vertices from
  // the origin and keeps the new codes only if no two vertices coincide.
  function automatic logic apply_to_walk_model(input logic cmd,
                                               input logic [PIVOT_W-1:0] piv,
                                               input logic sd,
                                               input logic [ROT_W-1:0] rot);
    code_t trial [WALK_LEN];
    int    pos_x [WALK_LEN];
    int    pos_y [WALK_LEN];
    int    pos_z [WALK_LEN];
    int    cur_x, cur_y, cur_z;
    int    lo, hi;
    logic  avoids;
    if (cmd == CMD_RESET) begin
      foreach (walk_model_codes[k]) walk_model_codes[k] = '0;
      return 1'b1;
    end
    trial = walk_model_codes;
    if (sd == SIDE_LOW) begin
      lo = 0;
      hi = (int'(piv) < WALK_LEN) ? int'(piv) : WALK_LEN;
    end else begin
      lo = int'(piv);
      hi = WALK_LEN;
    end
    for (int k = lo; k < hi; k++)
      trial[k] = code_t'((int'(trial[k]) + int'(rot)) % NUM_CODES);

    // Vertex 0 sits at the origin; the code of vertex 0 never moves anything.
    cur_x = 0;
    cur_y = 0;
    cur_z = 0;
    pos_x[0] = 0;
    pos_y[0] = 0;
    pos_z[0] = 0;
    for (int k = 1; k < WALK_LEN; k++) begin
      case (3'(trial[k]))
        STEP_POS_Y: cur_y++;
        STEP_POS_X: cur_x++;
        STEP_NEG_Y: cur_y--;
        STEP_NEG_X: cur_x--;
        STEP_POS_Z: cur_z++;
        STEP_NEG_Z: cur_z--;
        default: ;
      endcase
      pos_x[k] = cur_x;
      pos_y[k] = cur_y;
      pos_z[k] = cur_z;
    end

    avoids = 1'b1;
    for (int a = 0; a < WALK_LEN; a++)
      for (int b = a + 1; b < WALK_LEN; b++)
        if (pos_x[a] == pos_x[b] && pos_y[a] == pos_y[b] && pos_z[a] == pos_z[b])
          avoids = 1'b0;
    if (avoids) walk_model_codes = trial;
    return avoids;
  endfunction

  // Offers one transaction and holds it until the block takes it. Must be
  // called at a rising edge. When idling is on, valid may drop afterward for a
  // short burst; otherwise it stays high so back-to-back transactions follow.
  task automatic apply_command(input logic cmd, input logic [PIVOT_W-1:0] piv,
                               input logic sd, input logic [ROT_W-1:0] rot);
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    pivot_index_i <= piv;
    side_i        <= sd;
    rotation_i    <= rot;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    accepted_expected_q.push_back(apply_to_walk_model(cmd, piv, sd, rot));
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  // A pivot with a random pivot index and side and the given rotation.
  task automatic apply_random_pivot(input logic [ROT_W-1:0] rot);
    apply_command(CMD_PIVOT, PIVOT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                  rot);
  endtask

  // Corner moves from a straight walk: pivots that rotate no code and every
  // code, a rotation of zero, fold-backs that must be rejected, full reversals
  // that must be kept, and resets carrying extreme values in the ignored fields.
  task automatic test_directed_moves();
    apply_command(CMD_RESET, 4'd0, SIDE_LOW, 2'd0);
    apply_command(CMD_RESET, 4'd15, SIDE_HIGH, 2'd3);
    apply_command(CMD_PIVOT, 4'd0, SIDE_LOW, 2'd1);
    apply_command(CMD_PIVOT, 4'd0, SIDE_HIGH, 2'd0);
    apply_command(CMD_PIVOT, 4'd5, SIDE_LOW, 2'd0);
    apply_command(CMD_PIVOT, 4'd0, SIDE_HIGH, 2'd1);
    apply_command(CMD_PIVOT, 4'd15, SIDE_LOW, 2'd3);
    apply_command(CMD_PIVOT, 4'd8, SIDE_HIGH, 2'd2);
    apply_command(CMD_PIVOT, 4'd1, SIDE_HIGH, 2'd2);
    apply_command(CMD_PIVOT, 4'd15, SIDE_HIGH, 2'd3);
    apply_command(CMD_PIVOT, 4'd14, SIDE_LOW, 2'd2);
    apply_command(CMD_PIVOT, 4'd7, SIDE_HIGH, 2'd1);
    apply_command(CMD_PIVOT, 4'd9, SIDE_LOW, 2'd3);
    apply_command(CMD_PIVOT, 4'd10, SIDE_HIGH, 2'd3);
    apply_command(CMD_PIVOT, 4'd4, SIDE_HIGH, 2'd2);
    apply_command(CMD_RESET, 4'd10, SIDE_LOW, 2'd2);
    apply_command(CMD_PIVOT, 4'd2, SIDE_HIGH, 2'd1);
    apply_command(CMD_PIVOT, 4'd3, SIDE_HIGH, 2'd3);
    apply_command(CMD_PIVOT, 4'd12, SIDE_LOW, 2'd0);
    apply_command(CMD_RESET, 4'd5, SIDE_HIGH, 2'd1);
  endtask

  // Long chains of random pivots let the walk wander far from a straight line,
  // which is where the collision check does real work. Resets are rare so the
  // chains stay long, and a few pivots use a zero rotation. Idling is switched
  // off for one stretch in every three.
  task automatic test_random_walks(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      idle_enabled = ((i / 150) % 3) != 2;
      pick = $urandom_range(0, 99);
      if (pick < 3)
        apply_command(CMD_RESET, PIVOT_W'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)), ROT_W'($urandom_range(0, 3)));
      else if (pick < 8)
        apply_random_pivot(2'd0);
      else
        apply_random_pivot(ROT_W'($urandom_range(1, 3)));
    end
    idle_enabled = 1'b1;
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // pivots back to back. The output register fills, a finished pivot has to
  // park its result, and the block must stall its input until the hold ends.
  task automatic test_output_backpressure();
    idle_enabled     = 1'b0;
    hold_off_pending = 1'b1;
    for (int i = 0; i < 8; i++) apply_random_pivot(ROT_W'($urandom_range(1, 3)));
    idle_enabled = 1'b1;
  endtask

  // Closing run with both sides always ready, so transactions go through at
  // the block's own pace.
  task automatic test_full_rate(input int count);
    idle_enabled = 1'b0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 49) == 0)
        apply_command(CMD_RESET, PIVOT_W'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)), ROT_W'($urandom_range(0, 3)));
      else
        apply_random_pivot(ROT_W'($urandom_range(0, 3)));
    end
  endtask

  // Receiver: ready most of the time, with random stall bursts while idling is
  // on, and one long hold-off counted here when a test asks for it.
  initial begin
    int stall_len;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_ready_i <= 1'b0;
        for (int c = 0; c < HOLD_OFF_CYCLES; c++) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
        stall_len = $urandom_range(1, 13);
        out_ready_i <= 1'b0;
        repeat (stall_len) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: every output transaction must match the oldest prediction.
  always @(posedge clk_i) begin
    logic want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (accepted_expected_q.size() == 0) begin
        $error("accepted: no result expected, got %0b", accepted_o);
        error_count++;
      end else begin
        want = accepted_expected_q.pop_front();
        if (accepted_o !== want) begin
          $error("accepted: expected %0b, got %0b", want, accepted_o);
          error_count++;
        end
      end
    end
  end

  // Hard stop in case the block hangs. The slowest legal run is a few
  // milliseconds; this allows several times that.
  initial begin
    #15_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    error_count      = 0;
    idle_enabled     = 1'b1;
    hold_off_pending = 1'b0;
    foreach (walk_model_codes[k]) walk_model_codes[k] = '0;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    command_i     <= CMD_RESET;
    pivot_index_i <= '0;
    side_i        <= SIDE_LOW;
    rotation_i    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_moves();
    test_random_walks(1070);
    test_output_backpressure();
    test_full_rate(300);
    in_valid_i <= 1'b0;

    // Let every outstanding result drain, then give the block time to show
    // anything spurious before judging the run.
    while (accepted_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (accepted_expected_q.size() != 0) begin
      $error("accepted: %0d results never arrived", accepted_expected_q.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
